// File: hdl/srft_pkg.sv
package srft_pkg;

    localparam int ENTRIES_DEF = 5;
    localparam int REMOTES_DEF = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 32;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL  = 2'd1;
    localparam logic [1:0] ST_REMOTE_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] lstart;
        logic [ADDR_W-1:0] lend;
        logic [ADDR_W-1:0] rbcast;
        logic [ADDR_W-1:0] src;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_ADD,
        S_QRUN
    } t_state;

endpackage

// File: hdl/srft_front.sv
module srft_front import srft_pkg::*; (
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_local_ip,
    input  logic [ADDR_W-1:0] i_local_mask,
    input  logic [ADDR_W-1:0] i_remote_ip,
    input  logic [ADDR_W-1:0] i_remote_mask,
    input  logic [ADDR_W-1:0] i_source_ip,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic known_op;

    // An unused operation code is accepted and dropped here.
    assign known_op = (i_op == OP_CLEAR) || (i_op == OP_ADD) || (i_op == OP_QUERY);
    assign o_push   = i_start & ~i_busy & known_op;

    always_comb begin
        o_cmd.op     = i_op;
        o_cmd.lstart = i_local_ip & i_local_mask;
        o_cmd.lend   = (i_local_ip & i_local_mask) | ~i_local_mask;
        o_cmd.rbcast = (i_remote_ip & i_remote_mask) | ~i_remote_mask;
        o_cmd.src    = i_source_ip;
    end

endmodule

// File: hdl/srft_queue.sv
module srft_queue import srft_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_fill;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;

    assign o_full  = (r_fill == NW'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + NW'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: hdl/srft_back.sv
module srft_back import srft_pkg::*; #(
    parameter int ENTRIES           = ENTRIES_DEF,
    parameter int REMOTES_PER_ENTRY = REMOTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_strobe,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_dest_broadcast,
    output logic              o_last
);

    localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW    = (REMOTES_PER_ENTRY > 1) ? $clog2(REMOTES_PER_ENTRY) : 1;
    localparam int CW    = $clog2(REMOTES_PER_ENTRY + 1);
    localparam int DEPTH = ENTRIES * REMOTES_PER_ENTRY;
    localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    logic [ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0] r_start [ENTRIES];
    logic [ADDR_W-1:0] r_end   [ENTRIES];
    logic [CW-1:0]     r_count [ENTRIES];
    logic [ENTRIES-1:0] r_match;
    logic [RW-1:0]     r_ridx;
    logic [ADDR_W-1:0] r_mem [DEPTH];
    logic [ADDR_W-1:0] r_mem_q;
    logic              r_out_vld;
    logic [1:0]        r_out_status;
    logic              r_out_last;
    logic              r_out_q;

    logic              n_out_vld;
    logic [1:0]        n_out_status;
    logic              n_out_last;
    logic              n_out_q;
    logic              do_clear;
    logic              do_load_match;
    logic              do_add;
    logic              do_claim;
    logic              mem_we;
    logic [MW-1:0]     mem_waddr;
    logic [MW-1:0]     mem_raddr;

    logic [ENTRIES-1:0] match_now;
    logic              hit_any;
    logic [EW-1:0]     hit_idx;
    logic              free_any;
    logic [EW-1:0]     free_idx;
    logic [EW-1:0]     q_idx;
    logic [EW-1:0]     sel;
    logic [CW-1:0]     cnt_sel;
    logic [CW-1:0]     cnt_eff;
    logic [ENTRIES-1:0] rest;
    logic              more;
    logic              entry_done;

    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            if (r_cmd.op == OP_ADD) begin
                match_now[e] = r_valid[e] && (r_start[e] == r_cmd.lstart)
                               && (r_end[e] == r_cmd.lend);
            end else begin
                match_now[e] = r_valid[e] && (r_cmd.src >= r_start[e])
                               && (r_cmd.src <= r_end[e]) && (r_count[e] != '0);
            end
        end
    end

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        q_idx    = '0;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
            if (r_match[e]) begin
                hit_idx = EW'(e);
                q_idx   = EW'(e);
            end
            if (!r_valid[e]) begin
                free_idx = EW'(e);
            end
        end
    end

    assign hit_any    = |r_match;
    assign free_any   = ~&r_valid;
    assign sel        = (r_state == S_ADD) ? (hit_any ? hit_idx : free_idx) : q_idx;
    assign cnt_sel    = r_count[sel];
    assign cnt_eff    = hit_any ? cnt_sel : '0;
    assign rest       = r_match & ~(ENTRIES'(1) << q_idx);
    assign more       = |rest;
    assign entry_done = ((CW'(r_ridx) + CW'(1)) == cnt_sel);
    assign mem_waddr  = MW'(int'(sel) * REMOTES_PER_ENTRY + int'(cnt_eff));
    assign mem_raddr  = MW'(int'(q_idx) * REMOTES_PER_ENTRY + int'(r_ridx));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                if (r_cmd.op == OP_ADD) begin
                    n_state = S_ADD;
                end else if ((r_cmd.op == OP_QUERY) && (|match_now)) begin
                    n_state = S_QRUN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ADD: begin
                n_state = S_IDLE;
            end
            S_QRUN: begin
                if (entry_done && !more) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop         = 1'b0;
        do_clear      = 1'b0;
        do_load_match = 1'b0;
        do_add        = 1'b0;
        do_claim      = 1'b0;
        mem_we        = 1'b0;
        n_out_vld     = 1'b0;
        n_out_status  = ST_OK;
        n_out_last    = 1'b0;
        n_out_q       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop = ~i_empty;
            end
            S_MATCH: begin
                do_load_match = 1'b1;
                if (r_cmd.op == OP_CLEAR) begin
                    do_clear   = 1'b1;
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                end
            end
            S_ADD: begin
                n_out_vld  = 1'b1;
                n_out_last = 1'b1;
                if (!hit_any && !free_any) begin
                    n_out_status = ST_TABLE_FULL;
                end else if (cnt_eff >= CW'(REMOTES_PER_ENTRY)) begin
                    n_out_status = ST_REMOTE_FULL;
                end else begin
                    do_add   = 1'b1;
                    do_claim = ~hit_any;
                    mem_we   = 1'b1;
                end
            end
            S_QRUN: begin
                n_out_vld  = 1'b1;
                n_out_q    = 1'b1;
                n_out_last = entry_done & ~more;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_match   <= '0;
            r_ridx    <= '0;
            r_out_vld <= 1'b0;
            for (int e = 0; e < ENTRIES; e++) begin
                r_count[e] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (do_clear) begin
                r_valid <= '0;
                for (int e = 0; e < ENTRIES; e++) begin
                    r_count[e] <= '0;
                end
            end
            if (do_add) begin
                r_valid[sel] <= 1'b1;
                r_count[sel] <= cnt_eff + CW'(1);
            end
            if (do_load_match) begin
                r_match <= match_now;
                r_ridx  <= '0;
            end else if (r_state == S_QRUN) begin
                if (entry_done) begin
                    r_match <= rest;
                    r_ridx  <= '0;
                end else begin
                    r_ridx <= r_ridx + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (do_claim) begin
            r_start[sel] <= r_cmd.lstart;
            r_end[sel]   <= r_cmd.lend;
        end
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_q      <= n_out_q;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_cmd.rbcast;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    assign o_strobe         = r_out_vld;
    assign o_status         = r_out_status;
    assign o_last           = r_out_last;
    assign o_dest_broadcast = r_out_q ? r_mem_q : '0;

endmodule

// File: hdl/subnet_relay_fanout_table.sv
// Channel   Direction  Transfer when        Ports
// command   in         start & !busy        i_op, i_local_ip, i_local_mask, i_remote_ip,
//                                           i_remote_mask, i_source_ip
// result    out        o_strobe             o_status, o_dest_broadcast, o_last
//
// Commands enter a two-deep queue and are executed one at a time by the table engine.
// A popped command is registered, then handled in the match state (and for an add, in the
// add state); its result is registered. A query then gives one relay target per cycle,
// set by the single read port of the broadcast memory, whose read is registered.
// busy is high only while the queue is full. Reset is synchronous and empties the table.
// Each result is shown for one cycle and cannot be held off by the receiver.
module subnet_relay_fanout_table import srft_pkg::*; #(
    parameter int ENTRIES           = ENTRIES_DEF,
    parameter int REMOTES_PER_ENTRY = REMOTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_local_ip,
    input  logic [ADDR_W-1:0] i_local_mask,
    input  logic [ADDR_W-1:0] i_remote_ip,
    input  logic [ADDR_W-1:0] i_remote_mask,
    input  logic [ADDR_W-1:0] i_source_ip,
    output logic              o_strobe,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_dest_broadcast,
    output logic              o_last
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd front_cmd;
    t_cmd head_cmd;

    assign busy = q_full;

    srft_front u_front (
        .i_start       (start),
        .i_busy        (q_full),
        .i_op          (i_op),
        .i_local_ip    (i_local_ip),
        .i_local_mask  (i_local_mask),
        .i_remote_ip   (i_remote_ip),
        .i_remote_mask (i_remote_mask),
        .i_source_ip   (i_source_ip),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    srft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    srft_back #(
        .ENTRIES           (ENTRIES),
        .REMOTES_PER_ENTRY (REMOTES_PER_ENTRY)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (q_empty),
        .i_cmd            (head_cmd),
        .o_pop            (pop),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_dest_broadcast (o_dest_broadcast),
        .o_last           (o_last)
    );

endmodule

// File: tb/sv/srft_relay_checker.sv
module srft_relay_checker import srft_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_local_ip,
    input  logic [ADDR_W-1:0] i_local_mask,
    input  logic [ADDR_W-1:0] i_remote_ip,
    input  logic [ADDR_W-1:0] i_remote_mask,
    input  logic [ADDR_W-1:0] i_source_ip,
    input  logic              o_strobe,
    input  logic [1:0]        o_status,
    input  logic [ADDR_W-1:0] o_dest_broadcast,
    input  logic              o_last,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_checked,
    output int                o_table_full,
    output int                o_list_full
);

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] dest;
        logic              last;
    } t_relay_result;

    t_relay_result     relay_expected[$];
    logic              entry_used[ENTRIES_DEF];
    logic [ADDR_W-1:0] entry_lo[ENTRIES_DEF];
    logic [ADDR_W-1:0] entry_hi[ENTRIES_DEF];
    int                entry_fill[ENTRIES_DEF];
    logic [ADDR_W-1:0] entry_targets[ENTRIES_DEF][REMOTES_DEF];

    task automatic empty_relay_table();
        int e;
        for (e = 0; e < ENTRIES_DEF; e++) begin
            entry_used[e] = 1'b0;
            entry_lo[e]   = '0;
            entry_hi[e]   = '0;
            entry_fill[e] = 0;
        end
    endtask

    task automatic add_subnet_pair(input logic [ADDR_W-1:0] lip, input logic [ADDR_W-1:0] lmask,
                                   input logic [ADDR_W-1:0] rip, input logic [ADDR_W-1:0] rmask,
                                   output logic [1:0] status);
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] bcast;
        int                slot;
        int                e;
        lo     = lip & lmask;
        hi     = lo | ~lmask;
        bcast  = (rip & rmask) | ~rmask;
        slot   = -1;
        status = ST_OK;
        for (e = 0; e < ENTRIES_DEF; e++) begin
            if (slot < 0 && entry_used[e] && entry_lo[e] == lo && entry_hi[e] == hi) begin
                slot = e;
            end
        end
        if (slot < 0) begin
            for (e = 0; e < ENTRIES_DEF; e++) begin
                if (slot < 0 && !entry_used[e]) begin
                    slot = e;
                end
            end
            if (slot >= 0) begin
                entry_used[slot] = 1'b1;
                entry_lo[slot]   = lo;
                entry_hi[slot]   = hi;
                entry_fill[slot] = 0;
            end
        end
        if (slot < 0) begin
            status = ST_TABLE_FULL;
        end else if (entry_fill[slot] >= REMOTES_DEF) begin
            status = ST_REMOTE_FULL;
        end else begin
            entry_targets[slot][entry_fill[slot]] = bcast;
            entry_fill[slot] = entry_fill[slot] + 1;
        end
    endtask

    task automatic predict_command();
        t_relay_result res;
        logic [1:0]    status;
        int            total;
        int            n;
        int            e;
        int            r;
        case (i_op)
            OP_CLEAR: begin
                empty_relay_table();
                res = '{status: ST_OK, dest: '0, last: 1'b1};
                relay_expected.push_back(res);
            end
            OP_ADD: begin
                add_subnet_pair(i_local_ip, i_local_mask, i_remote_ip, i_remote_mask, status);
                res = '{status: status, dest: '0, last: 1'b1};
                relay_expected.push_back(res);
            end
            OP_QUERY: begin
                total = 0;
                for (e = 0; e < ENTRIES_DEF; e++) begin
                    if (entry_used[e] && i_source_ip >= entry_lo[e]
                            && i_source_ip <= entry_hi[e]) begin
                        total = total + entry_fill[e];
                    end
                end
                n = 0;
                for (e = 0; e < ENTRIES_DEF; e++) begin
                    if (entry_used[e] && i_source_ip >= entry_lo[e]
                            && i_source_ip <= entry_hi[e]) begin
                        for (r = 0; r < entry_fill[e]; r++) begin
                            res = '{status: ST_OK, dest: entry_targets[e][r],
                                    last: (n == total - 1)};
                            relay_expected.push_back(res);
                            n = n + 1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result();
        t_relay_result want;
        if (relay_expected.size() == 0) begin
            if (o_mismatches < 10) begin
                $display("Unexpected result: status %0d dest %h last %0d",
                         o_status, o_dest_broadcast, o_last);
            end
            o_mismatches <= o_mismatches + 1;
        end else begin
            want = relay_expected.pop_front();
            if (want.status != o_status || want.dest != o_dest_broadcast
                    || want.last != o_last) begin
                if (o_mismatches < 10) begin
                    $display("Mismatch: expected status %0d dest %h last %0d, got %0d %h %0d",
                             want.status, want.dest, want.last,
                             o_status, o_dest_broadcast, o_last);
                end
                o_mismatches <= o_mismatches + 1;
            end
            if (o_status == ST_TABLE_FULL) begin
                o_table_full <= o_table_full + 1;
            end
            if (o_status == ST_REMOTE_FULL) begin
                o_list_full <= o_list_full + 1;
            end
        end
        o_checked <= o_checked + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            empty_relay_table();
            relay_expected.delete();
            o_mismatches <= 0;
            o_checked    <= 0;
            o_table_full <= 0;
            o_list_full  <= 0;
        end else begin
            if (o_strobe) begin
                check_result();
            end
            if (start && !busy) begin
                predict_command();
            end
        end
        o_pending <= relay_expected.size();
    end

endmodule

// File: tb/sv/tb_subnet_relay_fanout_table.sv
module tb_subnet_relay_fanout_table;
    import srft_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 450;
    localparam int         POOL_SIZE    = 6;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 40;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        i_op = '0;
    logic [ADDR_W-1:0] i_local_ip = '0;
    logic [ADDR_W-1:0] i_local_mask = '0;
    logic [ADDR_W-1:0] i_remote_ip = '0;
    logic [ADDR_W-1:0] i_remote_mask = '0;
    logic [ADDR_W-1:0] i_source_ip = '0;
    logic              busy;
    logic              o_strobe;
    logic [1:0]        o_status;
    logic [ADDR_W-1:0] o_dest_broadcast;
    logic              o_last;

    int mismatches;
    int pending;
    int checked;
    int table_full_seen;
    int list_full_seen;
    int cycle_count = 0;
    int idle_pct = 0;
    int n_clears = 0;
    int n_adds = 0;
    int n_queries = 0;

    logic [ADDR_W-1:0] pool_ip[POOL_SIZE];
    logic [ADDR_W-1:0] pool_mask[POOL_SIZE];

    subnet_relay_fanout_table DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_local_ip(i_local_ip),
        .i_local_mask(i_local_mask),
        .i_remote_ip(i_remote_ip),
        .i_remote_mask(i_remote_mask),
        .i_source_ip(i_source_ip),
        .o_strobe(o_strobe),
        .o_status(o_status),
        .o_dest_broadcast(o_dest_broadcast),
        .o_last(o_last)
    );

    srft_relay_checker relay_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_local_ip(i_local_ip),
        .i_local_mask(i_local_mask),
        .i_remote_ip(i_remote_ip),
        .i_remote_mask(i_remote_mask),
        .i_source_ip(i_source_ip),
        .o_strobe(o_strobe),
        .o_status(o_status),
        .o_dest_broadcast(o_dest_broadcast),
        .o_last(o_last),
        .o_mismatches(mismatches),
        .o_pending(pending),
        .o_checked(checked),
        .o_table_full(table_full_seen),
        .o_list_full(list_full_seen)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] prefix_mask(input int plen);
        return (plen == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen));
    endfunction

    task automatic issue_command(input logic [1:0] op,
                                 input logic [ADDR_W-1:0] lip, input logic [ADDR_W-1:0] lmask,
                                 input logic [ADDR_W-1:0] rip, input logic [ADDR_W-1:0] rmask,
                                 input logic [ADDR_W-1:0] src);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start         <= 1'b0;
            i_op          <= 2'($urandom);
            i_local_ip    <= $urandom;
            i_source_ip   <= $urandom;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_op          <= op;
        i_local_ip    <= lip;
        i_local_mask  <= lmask;
        i_remote_ip   <= rip;
        i_remote_mask <= rmask;
        i_source_ip   <= src;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (op)
            OP_CLEAR: n_clears++;
            OP_ADD:   n_adds++;
            OP_QUERY: n_queries++;
            default: begin
            end
        endcase
    endtask

    task automatic build_subnet_pool();
        int k;
        int plen;
        for (k = 0; k < POOL_SIZE; k++) begin
            plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : $urandom_range(8, 30);
            pool_mask[k] = ($urandom_range(0, 9) == 0) ? $urandom : prefix_mask(plen);
            if (k > 0 && $urandom_range(0, 1) == 1) begin
                pool_ip[k] = pool_ip[0] ^ ($urandom & 32'h00ff_ffff);
            end else begin
                pool_ip[k] = $urandom;
            end
        end
    endtask

    task automatic random_command(output bit counted);
        int                pick;
        int                k;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] lip;
        logic [ADDR_W-1:0] lmask;
        longint unsigned   span;
        pick    = $urandom_range(0, 99);
        k       = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1)
                                               : $urandom_range(0, POOL_SIZE - 1);
        lo      = pool_ip[k] & pool_mask[k];
        hi      = lo | ~pool_mask[k];
        counted = 1'b1;
        if (pick < 3) begin
            issue_command(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
            counted = 1'b0;
        end else if (pick < 5) begin
            issue_command(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            build_subnet_pool();
        end else if (pick < 50) begin
            if ($urandom_range(0, 9) < 8) begin
                lip   = pool_ip[k] ^ ($urandom & ~pool_mask[k]);
                lmask = pool_mask[k];
            end else begin
                lip   = $urandom;
                lmask = ($urandom_range(0, 1) == 1) ? $urandom : prefix_mask($urandom_range(0, 32));
            end
            issue_command(OP_ADD, lip, lmask, $urandom,
                          ($urandom_range(0, 9) == 0) ? $urandom
                                                      : prefix_mask($urandom_range(0, 32)),
                          $urandom);
        end else begin
            span = longint'(hi) - longint'(lo) + 1;
            case ($urandom_range(0, 9))
                0:       src = lo;
                1:       src = hi;
                2:       src = lo - 1;
                3:       src = hi + 1;
                4, 5:    src = $urandom;
                default: src = lo + ADDR_W'({$urandom, $urandom} % span);
            endcase
            issue_command(OP_QUERY, $urandom, $urandom, $urandom, $urandom, src);
        end
    endtask

    initial begin
        int  done;
        bit  counted;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue_command(OP_QUERY, '0, '0, '0, '0, '0);
        issue_command(OP_UNUSED, '1, '1, '1, '1, '1);
        issue_command(OP_ADD, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, '0);
        issue_command(OP_ADD, 32'h0, 32'h0, 32'hffff_ffff, 32'h0, '0);
        issue_command(OP_ADD, 32'h0, 32'h0, 32'hffff_ffff, 32'h0, '0);
        issue_command(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h0a00_00ff, 32'hffff_ff00, '1);
        issue_command(OP_ADD, 32'h0a12_3456, 32'hff00_0000, 32'hc0a8_0001, 32'hffff_ff00, '0);
        issue_command(OP_ADD, 32'hc0a8_7f01, 32'hffff_0000, 32'h5555_aaaa, 32'haaaa_5555, '0);
        issue_command(OP_ADD, 32'h1234_5678, 32'hf0f0_f0f0, 32'h8000_0001, 32'hfffffffe, '0);
        issue_command(OP_ADD, 32'h0100_0000, 32'hff00_0000, 32'h0102_0304, 32'hffff_ffff, '0);
        issue_command(OP_ADD, 32'h7654_3210, 32'h0, 32'h2000_0000, 32'hf000_0000, '0);
        issue_command(OP_ADD, 32'h0, 32'h0, 32'hac10_0000, 32'hfff0_0000, '0);
        issue_command(OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0, '0);
        issue_command(OP_QUERY, '0, '0, '0, '0, 32'hffff_ffff);
        issue_command(OP_QUERY, '0, '0, '0, '0, 32'h0a12_3456);
        issue_command(OP_QUERY, '0, '0, '0, '0, 32'hc0a7_ffff);
        issue_command(OP_QUERY, '0, '0, '0, '0, 32'hc0a8_ffff);
        issue_command(OP_QUERY, '0, '0, '0, '0, 32'h0);
        issue_command(OP_CLEAR, '1, '1, '1, '1, '1);
        issue_command(OP_QUERY, '0, '0, '0, '0, 32'hffff_ffff);
        issue_command(OP_ADD, 32'h0a00_0001, 32'hff00_0000, 32'h0b00_0000, 32'hff00_0000, '0);
        issue_command(OP_QUERY, '0, '0, '0, '0, 32'h0a00_0000);

        build_subnet_pool();
        done = 0;
        while (done < RANDOM_ITEMS) begin
            case (done * 4 / RANDOM_ITEMS)
                1:       idle_pct = 74;
                2:       idle_pct = 37;
                default: idle_pct = 0;
            endcase
            random_command(counted);
            if (counted) begin
                done++;
            end
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Issued %0d clears, %0d adds and %0d queries across four idling phases.",
                 n_clears, n_adds, n_queries);
        $display("Checked %0d results, including %0d table-full and %0d list-full replies.",
                 checked, table_full_seen, list_full_seen);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: subnet_relay_fanout_table.f
hdl/srft_pkg.sv
hdl/srft_front.sv
hdl/srft_queue.sv
hdl/srft_back.sv
hdl/subnet_relay_fanout_table.sv
tb/sv/srft_relay_checker.sv
tb/sv/tb_subnet_relay_fanout_table.sv
